>>> rtl/core/frwa_pkg.sv
`timescale 1ns / 1ps
// shared constants and control types for the frame rate window average block
// no dependencies

package frwa_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int TIME_BITS_DEF  = 32;

	// window length register and sample count width
	localparam int LEN_BITS = 7;
	localparam logic [LEN_BITS-1:0] WL_RESET = 7'd16;

	// fraction bits of the time format, reciprocal numerator is 2^(2*FRAC_BITS)
	localparam int FRAC_BITS = 16;
	localparam int RATE_W    = 2 * FRAC_BITS + 1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic capture;
		logic apply;
		logic mean_start;
		logic rate_start;
		logic div_step;
		logic out_load;
	} frwa_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} frwa_status_t;

endpackage

>>> rtl/core/frame_rate_window_average.sv
`timescale 1ns / 1ps
// top level of the frame rate window average block: controller plus datapath
// depends on frwa_pkg, frwa_ctrl, frwa_dp
//
//  port group   direction  handshake            payload
//  in           receive    in_valid / in_stall  command, frame_time
//  out          send       out_valid/out_stall  average_time, frame_rate, samples_held
//  cfg          receive    cfg_wr_en            cfg_wr_data (window_length)
//
// one item at a time: transfer, a window update, then a restoring divider shared by
// the mean (TIME_BITS + log2(WINDOW_MAX) steps) and the reciprocal (33 steps)
// sets the pace; the next item is taken only once the last one has
// been loaded into the output register
// a finished result sits in the output register, so a stalled output blocks only
// the completion of the following item; reset empties the window and sets length 16
// a configuration write also empties the window

module frame_rate_window_average #(
	parameter int WINDOW_MAX = frwa_pkg::WINDOW_MAX_DEF,
	parameter int TIME_BITS  = frwa_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frwa_pkg::LEN_BITS-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [TIME_BITS-1:0]          frame_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [TIME_BITS-1:0]          average_time,
	output logic [TIME_BITS-1:0]          frame_rate,
	output logic [frwa_pkg::LEN_BITS-1:0] samples_held
);
	import frwa_pkg::*;

	frwa_cmd_t    cmd;
	frwa_status_t status;

	frwa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	frwa_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.TIME_BITS  (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.command      (command),
		.frame_time   (frame_time),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.average_time (average_time),
		.frame_rate   (frame_rate),
		.samples_held (samples_held)
	);

endmodule

>>> rtl/core/frwa_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for the frame rate window average block
// depends on frwa_pkg

module frwa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  frwa_pkg::frwa_status_t status,
	output frwa_pkg::frwa_cmd_t    cmd
);
	import frwa_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_APPLY    = 3'd1;
	localparam logic [2:0] S_MEAN_LD  = 3'd2;
	localparam logic [2:0] S_MEAN_RUN = 3'd3;
	localparam logic [2:0] S_RATE_LD  = 3'd4;
	localparam logic [2:0] S_RATE_RUN = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_MEAN_LD;
			end
			S_MEAN_LD: begin
				cmd.mean_start = 1'b1;
				state_d        = S_MEAN_RUN;
			end
			S_MEAN_RUN: begin
				if (status.div_done) begin
					state_d = S_RATE_LD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_RATE_LD: begin
				cmd.rate_start = 1'b1;
				state_d        = S_RATE_RUN;
			end
			S_RATE_RUN: begin
				if (status.div_done) begin
					state_d = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DONE: begin
				// wait until the output register can take the result
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/frwa_dp.sv
`timescale 1ns / 1ps
// datapath: sample ring memory, running sum, shared restoring divider, output register
// depends on frwa_pkg

module frwa_dp #(
	parameter int WINDOW_MAX = frwa_pkg::WINDOW_MAX_DEF,
	parameter int TIME_BITS  = frwa_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frwa_pkg::LEN_BITS-1:0] cfg_wr_data,
	input  logic                          command,
	input  logic [TIME_BITS-1:0]          frame_time,
	input  frwa_pkg::frwa_cmd_t           cmd,
	output frwa_pkg::frwa_status_t        status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [TIME_BITS-1:0]          average_time,
	output logic [TIME_BITS-1:0]          frame_rate,
	output logic [frwa_pkg::LEN_BITS-1:0] samples_held
);
	import frwa_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_MAX);
	localparam int SUM_W = TIME_BITS + IDX_W;
	localparam int EXT_W = IDX_W + LEN_BITS + 1;
	localparam int DW    = (SUM_W > RATE_W) ? SUM_W : RATE_W;
	localparam int CNT_W = $clog2(DW + 1);
	localparam logic [RATE_W-1:0] RATE_NUM = {1'b1, {(RATE_W - 1){1'b0}}};

	logic [TIME_BITS-1:0] sample_mem [WINDOW_MAX];

	logic [LEN_BITS-1:0]  wl_q;
	logic [LEN_BITS-1:0]  held_q;
	logic [IDX_W-1:0]     oldest_q;
	logic [SUM_W-1:0]     sum_q;
	logic [TIME_BITS-1:0] mean_q;
	logic                 op_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] rd_q;

	logic [TIME_BITS-1:0] div_rem_q;
	logic [TIME_BITS-1:0] div_den_q;
	logic [DW-1:0]        div_quo_q;
	logic [CNT_W-1:0]     div_cnt_q;

	logic                 out_valid_q;
	logic [TIME_BITS-1:0] avg_out_q;
	logic [TIME_BITS-1:0] rate_out_q;
	logic [LEN_BITS-1:0]  held_out_q;

	logic [LEN_BITS-1:0]  eff_len;
	logic [EXT_W-1:0]     wl_ext;
	logic                 window_full;
	logic [EXT_W-2:0]     held_ext;
	logic [IDX_W-1:0]     held_addr;
	logic [EXT_W-2:0]     oldest_inc;
	logic [EXT_W-2:0]     len_ext;
	logic [IDX_W-1:0]     oldest_nxt;
	logic [IDX_W-1:0]     mem_waddr;
	logic                 mem_we;
	logic [SUM_W-1:0]     time_ext;
	logic [SUM_W-1:0]     drop_ext;

	logic [TIME_BITS:0]   rem_sh;
	logic                 rem_ge;
	logic [TIME_BITS:0]   rem_diff;
	logic [TIME_BITS-1:0] mean_val;
	logic [RATE_W+TIME_BITS-1:0] rate_ext;
	logic                 rate_sat;
	logic [TIME_BITS-1:0] rate_val;

	// zero selects one, anything above the memory depth is clamped
	assign wl_ext = {{(IDX_W + 1){1'b0}}, wl_q};
	always_comb begin
		priority if (wl_q == '0) begin
			eff_len = LEN_BITS'(1);
		end else if (wl_ext > EXT_W'(WINDOW_MAX)) begin
			eff_len = LEN_BITS'(WINDOW_MAX);
		end else begin
			eff_len = wl_q;
		end
	end

	assign window_full = (held_q >= eff_len);
	assign held_ext    = {{IDX_W{1'b0}}, held_q};
	assign held_addr   = held_ext[IDX_W-1:0];
	assign oldest_inc  = {{LEN_BITS{1'b0}}, oldest_q} + (EXT_W - 1)'(1);
	assign len_ext     = {{IDX_W{1'b0}}, eff_len};
	assign oldest_nxt  = (oldest_inc >= len_ext) ? '0 : oldest_inc[IDX_W-1:0];
	assign mem_waddr   = window_full ? oldest_q : held_addr;
	assign mem_we      = cmd.apply && (op_q == OP_SAMPLE);
	assign time_ext    = {{IDX_W{1'b0}}, time_q};
	assign drop_ext    = {{IDX_W{1'b0}}, rd_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[mem_waddr] <= time_q;
		end
	end

	// the oldest sample is fetched on the transfer and used in the cycle after it
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q   <= sample_mem[oldest_q];
			op_q   <= command;
			time_q <= frame_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q     <= WL_RESET;
			held_q   <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
		end else if (cfg_wr_en) begin
			wl_q     <= cfg_wr_data;
			held_q   <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
		end else if (cmd.apply) begin
			if (op_q == OP_CLEAR) begin
				held_q   <= '0;
				oldest_q <= '0;
				sum_q    <= '0;
			end else if (!window_full) begin
				held_q <= held_q + LEN_BITS'(1);
				sum_q  <= sum_q + time_ext;
			end else begin
				oldest_q <= oldest_nxt;
				sum_q    <= sum_q - drop_ext + time_ext;
			end
		end
	end

	// one quotient bit per cycle
	assign rem_sh   = {div_rem_q, div_quo_q[DW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, div_den_q});
	assign rem_diff = rem_sh - {1'b0, div_den_q};

	assign mean_val = (held_q == '0) ? '0 : div_quo_q[TIME_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mean_start) begin
			div_rem_q <= '0;
			div_den_q <= {{(TIME_BITS - LEN_BITS){1'b0}}, held_q};
			div_quo_q <= DW'(sum_q) << (DW - SUM_W);
		end else if (cmd.rate_start) begin
			div_rem_q <= '0;
			div_den_q <= mean_val;
			div_quo_q <= DW'(RATE_NUM) << (DW - RATE_W);
		end else if (cmd.div_step) begin
			div_rem_q <= rem_ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			mean_q    <= '0;
		end else if (cmd.mean_start) begin
			div_cnt_q <= CNT_W'(SUM_W);
		end else if (cmd.rate_start) begin
			div_cnt_q <= CNT_W'(RATE_W);
			mean_q    <= mean_val;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - CNT_W'(1);
		end
	end

	assign rate_ext = {{TIME_BITS{1'b0}}, div_quo_q[RATE_W-1:0]};
	assign rate_sat = (rate_ext > {{RATE_W{1'b0}}, {TIME_BITS{1'b1}}});
	always_comb begin
		priority if (mean_q == '0) begin
			rate_val = '0;
		end else if (rate_sat) begin
			rate_val = '1;
		end else begin
			rate_val = rate_ext[TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			avg_out_q  <= mean_q;
			rate_out_q <= rate_val;
			held_out_q <= held_q;
		end
	end

	assign status.div_done = (div_cnt_q == '0);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign average_time = avg_out_q;
	assign frame_rate   = rate_out_q;
	assign samples_held = held_out_q;

endmodule
